// ===== rtl/rtd_pkg.sv =====
`default_nettype none

package rtd_pkg;

	// table geometry
	localparam int STORED_ENTRIES = 106;
	localparam int TABLE_ENTRIES_DEF = 106;
	localparam int IDX_W = 7;
	localparam int FRAC_BITS = 24;
	localparam int BASE_TEMP_CENTI = -20000;
	localparam int STEP_CENTI = 1000;

	// register widths and reset values
	localparam int GAIN_W = 24;
	localparam int OFFS_W = 33;
	localparam int TEMP_W = 18;
	localparam int CODE_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [GAIN_W-1:0] GAIN_RST = 24'd52009;
	localparam logic [OFFS_W-1:0] OFFS_RST = 33'd1616686088;
	localparam logic signed [TEMP_W-1:0] THR_RST = 18'sd4000;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN   = 2'd0,
		REG_OFFSET = 2'd1,
		REG_THRESH = 2'd2
	} reg_idx_t;

	// range status codes
	typedef enum logic [1:0] {
		RS_IN    = 2'd0,
		RS_ABOVE = 2'd1,
		RS_BELOW = 2'd2
	} range_t;

	// PT100 resistance, hundredths of an ohm, -200 C to 850 C in 10 C steps
	localparam logic [15:0] RTD_TBL [STORED_ENTRIES] = '{
		16'd1852, 16'd2283, 16'd2710, 16'd3134, 16'd3554, 16'd3972, 16'd4388, 16'd4800,
		16'd5211, 16'd5619, 16'd6026, 16'd6430, 16'd6833, 16'd7233, 16'd7633, 16'd8031,
		16'd8427, 16'd8822, 16'd9216, 16'd9609, 16'd10000, 16'd10390, 16'd10779,
		16'd11167, 16'd11554, 16'd11940, 16'd12324, 16'd12708, 16'd13090, 16'd13471,
		16'd13851, 16'd14229, 16'd14607, 16'd14983, 16'd15358, 16'd15733, 16'd16105,
		16'd16477, 16'd16848, 16'd17217, 16'd17586, 16'd17953, 16'd18319, 16'd18684,
		16'd19047, 16'd19410, 16'd19771, 16'd20131, 16'd20490, 16'd20848, 16'd21205,
		16'd21561, 16'd21915, 16'd22268, 16'd22621, 16'd22972, 16'd23321, 16'd23670,
		16'd24018, 16'd24364, 16'd24709, 16'd25053, 16'd25396, 16'd25738, 16'd26078,
		16'd26418, 16'd26756, 16'd27093, 16'd27429, 16'd27764, 16'd28098, 16'd28430,
		16'd28762, 16'd29092, 16'd29421, 16'd29749, 16'd30075, 16'd30401, 16'd30725,
		16'd31049, 16'd31371, 16'd31692, 16'd32012, 16'd32330, 16'd32648, 16'd32964,
		16'd33279, 16'd33593, 16'd33906, 16'd34218, 16'd34528, 16'd34838, 16'd35146,
		16'd35453, 16'd35759, 16'd36064, 16'd36367, 16'd36670, 16'd36971, 16'd37271,
		16'd37570, 16'd37868, 16'd38165, 16'd38460, 16'd38755, 16'd39048
	};

	function automatic logic [15:0] rtd_entry(input logic [IDX_W-1:0] idx);
		logic [15:0] v;
		v = '0;
		if (int'(idx) < STORED_ENTRIES) begin
			v = RTD_TBL[idx];
		end
		return v;
	endfunction

	// two restoring division steps; remainder stays below divisor if it starts below it
	typedef struct packed {
		logic [8:0] rem;
		logic [1:0] qb;
	} div2_t;

	function automatic div2_t div_step2(input logic [8:0] rem, input logic [1:0] bits,
			input logic [8:0] d);
		div2_t o;
		logic [9:0] t;
		logic [8:0] r;
		r = rem;
		o.qb = '0;
		for (int i = 1; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				o.qb[i] = 1'b1;
			end
			r = t[8:0];
		end
		o.rem = r;
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rtd_resistance_to_temperature.sv =====
`default_nettype none

// PT100 linearizer: each adc_code word becomes R = code*gain + offset (ohms, 24 fraction
// bits), is placed in a constant 10-degree resistance table, and is interpolated to
// hundredths of a degree with truncation; readings off the table clamp to the end
// temperatures and are flagged in range_status, and alarm compares the result against the
// threshold register. The pipeline is 12 register stages deep (multiply, offset add, x100
// scale, two binary-search stages, interpolation multiply, five radix-4 divider stages,
// output register) and takes one word every cycle while in_stall is low; a stall
// only holds the stages that are full. Registers are written on cfg_valid with cfg_ready
// always high, and must be written only while the pipeline is empty.
module rtd_resistance_to_temperature #(
	parameter int TABLE_ENTRIES = rtd_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rtd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rtd_pkg::OFFS_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [rtd_pkg::CODE_W-1:0]         adc_code,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [rtd_pkg::TEMP_W-1:0]       temperature,
	output logic                                    alarm,
	output logic [1:0]                              range_status
);

	localparam int N_USED = (TABLE_ENTRIES > rtd_pkg::STORED_ENTRIES) ?
		rtd_pkg::STORED_ENTRIES : ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
	localparam int IW = rtd_pkg::IDX_W;
	localparam logic [IW-1:0] SEG_MAX = IW'(N_USED - 2);
	localparam logic [IW-1:0] LAST_IDX = IW'(N_USED - 1);
	localparam int TEMP_TOP = rtd_pkg::BASE_TEMP_CENTI + (N_USED - 1) * rtd_pkg::STEP_CENTI;
	localparam int NS = 12;

	// configuration registers
	logic [rtd_pkg::GAIN_W-1:0] gain_q;
	logic [rtd_pkg::OFFS_W-1:0] offs_q;
	logic signed [rtd_pkg::TEMP_W-1:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= rtd_pkg::GAIN_RST;
			offs_q <= rtd_pkg::OFFS_RST;
			thr_q <= rtd_pkg::THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rtd_pkg::REG_GAIN:   gain_q <= cfg_data[rtd_pkg::GAIN_W-1:0];
				rtd_pkg::REG_OFFSET: offs_q <= cfg_data;
				rtd_pkg::REG_THRESH: thr_q <= cfg_data[rtd_pkg::TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits and per-stage load enables
	logic [NS:1] vld_s;
	logic [NS-1:0] vin;
	logic [NS:1] load;

	assign vin = {vld_s[NS-1:1], in_valid};

	always_comb begin
		load[NS] = !vld_s[NS] || !out_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			load[k] = !vld_s[k] || load[k+1];
		end
	end

	assign in_stall = !load[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (load[k]) vld_s[k] <= vin[k-1];
			end
		end
	end

	// stage 1: code times gain
	logic [39:0] prod_s1;
	always_ff @(posedge clk) begin
		if (load[1]) prod_s1 <= 40'(adc_code) * 40'(gain_q);
	end

	// stage 2: add offset
	logic [40:0] r_s2;
	always_ff @(posedge clk) begin
		if (load[2]) r_s2 <= 41'(prod_s1) + 41'(offs_q);
	end

	// stage 3: scale by 100, split integer centiohms and fraction
	logic [47:0] r100;
	logic [23:0] h_s3, l_s3, h_s4, l_s4, h_s5, l_s5;
	assign r100 = 48'(r_s2) * 48'd100;
	always_ff @(posedge clk) begin
		if (load[3]) begin
			h_s3 <= r100[47:24];
			l_s3 <= r100[23:0];
		end
	end

	// sideband carried down to the output
	logic [IW-1:0] seg_s [4:11];
	rtd_pkg::range_t st_s [4:11];

	// stage 4: range check and upper search bits
	logic [IW-1:0] seg4, cand4, seg5, cand5;
	logic [15:0] top_ent, bot_ent;
	rtd_pkg::range_t st4;

	always_comb begin
		top_ent = rtd_pkg::rtd_entry(LAST_IDX);
		bot_ent = rtd_pkg::rtd_entry('0);
		if ((h_s3 > 24'(top_ent)) || ((h_s3 == 24'(top_ent)) && (l_s3 != '0))) begin
			st4 = rtd_pkg::RS_ABOVE;
		end else if (h_s3 < 24'(bot_ent)) begin
			st4 = rtd_pkg::RS_BELOW;
		end else begin
			st4 = rtd_pkg::RS_IN;
		end
		seg4 = '0;
		cand4 = '0;
		for (int b = IW - 1; b >= 4; b--) begin
			cand4 = seg4 | (IW'(1) << b);
			if ((cand4 <= SEG_MAX) && (24'(rtd_pkg::rtd_entry(cand4)) <= h_s3)) seg4 = cand4;
		end
	end

	always_ff @(posedge clk) begin
		if (load[4]) begin
			h_s4 <= h_s3;
			l_s4 <= l_s3;
		end
	end

	// stage 5: lower search bits
	always_comb begin
		seg5 = seg_s[4];
		cand5 = '0;
		for (int b = 3; b >= 0; b--) begin
			cand5 = seg5 | (IW'(1) << b);
			if ((cand5 <= SEG_MAX) && (24'(rtd_pkg::rtd_entry(cand5)) <= h_s4)) seg5 = cand5;
		end
	end

	always_ff @(posedge clk) begin
		if (load[5]) begin
			h_s5 <= h_s4;
			l_s5 <= l_s4;
		end
	end

	// stage 6: numerator (R - lo) * 1000 / 2^24 and segment span
	logic [15:0] lo_ent, hi_ent;
	logic [9:0] dh;
	logic [43:0] num;
	logic [18:0] qn;
	logic [8:0] dv_d_s [6:11];
	logic [8:0] dv_rem_s [6:11];
	logic [9:0] dv_bits_s [6:11];
	logic [9:0] dv_quo_s [6:11];

	always_comb begin
		lo_ent = rtd_pkg::rtd_entry(seg_s[5]);
		hi_ent = rtd_pkg::rtd_entry(seg_s[5] + IW'(1));
		dh = 10'(h_s5 - 24'(lo_ent));
		num = 44'({dh, l_s5}) * 44'd1000;
		qn = num[42:24];
	end

	// stages 7..11: divider, two quotient bits per stage
	rtd_pkg::div2_t dstep [7:11];
	always_comb begin
		for (int k = 7; k <= 11; k++) begin
			dstep[k] = rtd_pkg::div_step2(dv_rem_s[k-1], dv_bits_s[k-1][9:8], dv_d_s[k-1]);
		end
	end

	// sideband and divider registers, stages 4..11
	always_ff @(posedge clk) begin
		if (load[4]) begin
			seg_s[4] <= seg4;
			st_s[4] <= st4;
		end
		if (load[5]) begin
			seg_s[5] <= seg5;
			st_s[5] <= st_s[4];
		end
		if (load[6]) begin
			dv_d_s[6] <= 9'(hi_ent - lo_ent);
			dv_rem_s[6] <= qn[18:10];
			dv_bits_s[6] <= qn[9:0];
			dv_quo_s[6] <= '0;
			seg_s[6] <= seg_s[5];
			st_s[6] <= st_s[5];
		end
		for (int k = 7; k <= 11; k++) begin
			if (load[k]) begin
				dv_d_s[k] <= dv_d_s[k-1];
				dv_rem_s[k] <= dstep[k].rem;
				dv_bits_s[k] <= {dv_bits_s[k-1][7:0], 2'b00};
				dv_quo_s[k] <= {dv_quo_s[k-1][7:0], dstep[k].qb};
				seg_s[k] <= seg_s[k-1];
				st_s[k] <= st_s[k-1];
			end
		end
	end

	// stage 12: temperature, alarm, status
	logic [9:0] frac;
	logic [16:0] seg_c;
	logic signed [rtd_pkg::TEMP_W-1:0] tmp;
	logic signed [rtd_pkg::TEMP_W-1:0] temp_s12;
	logic alarm_s12;
	logic [1:0] rs_s12;

	always_comb begin
		frac = (dv_quo_s[11] > 10'(rtd_pkg::STEP_CENTI)) ? 10'(rtd_pkg::STEP_CENTI) :
			dv_quo_s[11];
		seg_c = 17'(seg_s[11]) * 17'(rtd_pkg::STEP_CENTI);
		unique case (st_s[11])
			rtd_pkg::RS_ABOVE: tmp = rtd_pkg::TEMP_W'(TEMP_TOP);
			rtd_pkg::RS_BELOW: tmp = rtd_pkg::TEMP_W'(rtd_pkg::BASE_TEMP_CENTI);
			default: tmp = rtd_pkg::TEMP_W'(rtd_pkg::BASE_TEMP_CENTI) +
				signed'(18'(seg_c)) + signed'(18'(frac));
		endcase
	end

	always_ff @(posedge clk) begin
		if (load[12]) begin
			temp_s12 <= tmp;
			alarm_s12 <= (tmp > thr_q);
			rs_s12 <= st_s[11];
		end
	end

	assign out_valid = vld_s[NS];
	assign temperature = temp_s12;
	assign alarm = alarm_s12;
	assign range_status = rs_s12;

endmodule

`default_nettype wire
